// ===== design/pcrg_pkg.sv =====
// Shared types, widths and register reset values for the pinhole camera ray generator.
package pcrg_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int LANE_W    = 16;
  localparam int REG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam int NORM_W   = 30;
  localparam int NORM_TOP = 29;
  localparam int SQ_W     = 2 * NORM_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int LEN_W    = SUM_W / 2;
  localparam int FRAC_W   = 14;
  localparam int Q_W      = FRAC_W + 1;
  localparam int REM_W    = NORM_W + FRAC_W + 1;
  localparam int DIR_W    = 16;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

  localparam logic [REG_W-1:0] CENTER_RST   = 48'h0000_0000_0000;
  localparam logic [REG_W-1:0] APERTURE_RST = 48'h1000_1000_1000;
  localparam logic [REG_W-1:0] EYE_RST      = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] LEFT_RST     = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] UP_RST       = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER   = 3'd0,
    REG_APERTURE = 3'd1,
    REG_EYE      = 3'd2,
    REG_LEFT     = 3'd3,
    REG_UP       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] center;
    logic [REG_W-1:0] aperture;
    logic [REG_W-1:0] eye;
    logic [REG_W-1:0] left;
    logic [REG_W-1:0] up;
  } regs_t;

  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   degen;
  } norm_item_t;

  typedef struct packed {
    logic [2:0][LANE_W-1:0] origin;
    logic [2:0][DIR_W-1:0]  dir;
    logic                   degen;
  } ray_pl_t;

endpackage

// ===== design/pcrg_coord_if.sv =====
// Input channel: one image coordinate triple per request.
interface pcrg_coord_if #(
  parameter int COORD_WIDTH = pcrg_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] image_x;
  logic signed [COORD_WIDTH-1:0] image_y;
  logic signed [COORD_WIDTH-1:0] image_z;

  modport source (output valid, image_x, image_y, image_z, input ready);
  modport sink   (input valid, image_x, image_y, image_z, output ready);
endinterface

// ===== design/pcrg_ray_if.sv =====
// Output channel: one ray (origin, unit direction, degenerate flag) per request.
interface pcrg_ray_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcrg_pkg::LANE_W-1:0]  origin_x;
  logic signed [pcrg_pkg::LANE_W-1:0]  origin_y;
  logic signed [pcrg_pkg::LANE_W-1:0]  origin_z;
  logic signed [pcrg_pkg::DIR_W-1:0]   dir_x;
  logic signed [pcrg_pkg::DIR_W-1:0]   dir_y;
  logic signed [pcrg_pkg::DIR_W-1:0]   dir_z;
  logic                                degenerate;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, degenerate,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, degenerate,
                  output ready);
endinterface

// ===== design/pcrg_cfg_if.sv =====
// Configuration write channel: register index and write data per request.
interface pcrg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcrg_pkg::CFG_IDX_W-1:0]    index;
  logic [pcrg_pkg::REG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pcrg_regs.sv =====
// Configuration register file: centre, aperture and the three basis columns.
module pcrg_regs (
  input  logic              clk,
  input  logic              rst,
  pcrg_cfg_if.sink          cfg,
  output pcrg_pkg::regs_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.center   <= pcrg_pkg::CENTER_RST;
      regs.aperture <= pcrg_pkg::APERTURE_RST;
      regs.eye      <= pcrg_pkg::EYE_RST;
      regs.left     <= pcrg_pkg::LEFT_RST;
      regs.up       <= pcrg_pkg::UP_RST;
    end else if (cfg.valid) begin
      case (pcrg_pkg::cfg_reg_t'(cfg.index))
        pcrg_pkg::REG_CENTER:   regs.center   <= cfg.data;
        pcrg_pkg::REG_APERTURE: regs.aperture <= cfg.data;
        pcrg_pkg::REG_EYE:      regs.eye      <= cfg.data;
        pcrg_pkg::REG_LEFT:     regs.left     <= cfg.data;
        pcrg_pkg::REG_UP:       regs.up       <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pcrg_front.sv =====
// Front pipeline: aperture scale, basis transform, magnitude, normalising shift, sum of squares.
module pcrg_front #(
  parameter int COORD_WIDTH = pcrg_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [COORD_WIDTH-1:0] img_x,
  input  logic signed [COORD_WIDTH-1:0] img_y,
  input  logic signed [COORD_WIDTH-1:0] img_z,
  input  pcrg_pkg::regs_t               regs,
  output logic                          out_vld,
  output logic [pcrg_pkg::SUM_W-1:0]    sum,
  output pcrg_pkg::norm_item_t          item
);

  localparam int LW    = pcrg_pkg::LANE_W;
  localparam int NW    = pcrg_pkg::NORM_W;
  localparam int AW    = COORD_WIDTH + LW;
  localparam int PW    = AW + LW;
  localparam int VW    = PW + 2;
  localparam int MW    = VW;
  localparam int POS_W = $clog2(MW);
  localparam int SH_W  = MW + pcrg_pkg::NORM_TOP;
  localparam int NSTG  = 8;

  logic [NSTG-1:0] vld;

  logic signed [COORD_WIDTH-1:0] img [3];
  logic signed [LW-1:0]          ap [3];
  logic signed [LW-1:0]          col [3][3];

  logic signed [AW-1:0] a [3];
  logic signed [PW-1:0] p [3][3];
  logic signed [VW-1:0] v [3];
  logic [MW-1:0]        mag4 [3];
  logic [2:0]           neg4;
  logic [MW-1:0]        mag5 [3];
  logic [2:0]           neg5;
  logic [POS_W-1:0]     pos5;
  logic                 degen5;
  logic [NW-1:0]        n6 [3];
  logic [2:0]           neg6;
  logic                 degen6;
  logic [NW-1:0]        n7 [3];
  logic [pcrg_pkg::SQ_W-1:0] sq7 [3];
  logic [2:0]           neg7;
  logic                 degen7;
  logic [pcrg_pkg::SUM_W-1:0] sum8;
  pcrg_pkg::norm_item_t item8;

  logic [MW-1:0]    orv;
  logic [POS_W-1:0] pos_c;
  logic [SH_W-1:0]  wide [3];

  assign img[0] = img_x;
  assign img[1] = img_y;
  assign img[2] = img_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ap[k]     = regs.aperture[LW*k +: LW];
      col[0][k] = regs.eye[LW*k +: LW];
      col[1][k] = regs.left[LW*k +: LW];
      col[2][k] = regs.up[LW*k +: LW];
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    orv   = mag4[0] | mag4[1] | mag4[2];
    pos_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) pos_c = POS_W'(i);
    end
  end

  // put the leading one at the top normalised bit; bits below truncate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide[k] = {mag5[k], {pcrg_pkg::NORM_TOP{1'b0}}} >> pos5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a[k] <= AW'(img[k]) * AW'(ap[k]);
        for (int j = 0; j < 3; j++) begin
          p[k][j] <= PW'(col[j][k]) * PW'(a[j]);
        end
        v[k]    <= VW'(p[k][0]) + VW'(p[k][1]) + VW'(p[k][2]);
        neg4[k] <= v[k][VW-1];
        mag4[k] <= v[k][VW-1] ? MW'(-v[k]) : MW'(v[k]);
        mag5[k] <= mag4[k];
        n6[k]   <= wide[k][NW-1:0];
        n7[k]   <= n6[k];
        sq7[k]  <= pcrg_pkg::SQ_W'(n6[k]) * pcrg_pkg::SQ_W'(n6[k]);
        item8.mag[k] <= n7[k];
      end
      neg5   <= neg4;
      pos5   <= pos_c;
      degen5 <= (orv == '0);
      neg6   <= neg5;
      degen6 <= degen5;
      neg7   <= neg6;
      degen7 <= degen6;
      sum8   <= pcrg_pkg::SUM_W'(sq7[0]) + pcrg_pkg::SUM_W'(sq7[1])
              + pcrg_pkg::SUM_W'(sq7[2]);
      item8.neg   <= neg7;
      item8.degen <= degen7;
    end
  end

  assign out_vld = vld[NSTG-1];
  assign sum     = sum8;
  assign item    = item8;

endmodule

// ===== design/pcrg_isqrt.sv =====
// Integer square root pipeline, one result bit per stage.
module pcrg_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [pcrg_pkg::SUM_W-1:0]  sum,
  input  pcrg_pkg::norm_item_t        in_item,
  output logic                        out_vld,
  output logic [pcrg_pkg::LEN_W-1:0]  len,
  output pcrg_pkg::norm_item_t        out_item
);

  localparam int SW    = pcrg_pkg::SUM_W;
  localparam int RW    = SW + 1;
  localparam int STEPS = pcrg_pkg::LEN_W;

  logic [STEPS-1:0]     vld;
  logic [SW-1:0]        rem    [STEPS];
  logic [RW-1:0]        root   [STEPS];
  pcrg_pkg::norm_item_t itm    [STEPS];

  logic [SW-1:0]        s_src  [STEPS];
  logic [RW-1:0]        r_src  [STEPS];
  pcrg_pkg::norm_item_t i_src  [STEPS];
  logic [RW-1:0]        qb     [STEPS];
  logic [RW-1:0]        trial  [STEPS];
  logic [SW-1:0]        rem_n  [STEPS];
  logic [RW-1:0]        root_n [STEPS];

  always_comb begin
    s_src[0] = sum;
    r_src[0] = '0;
    i_src[0] = in_item;
    for (int i = 1; i < STEPS; i++) begin
      s_src[i] = rem[i-1];
      r_src[i] = root[i-1];
      i_src[i] = itm[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      qb[i]    = RW'(1) << (2 * (STEPS - 1 - i));
      trial[i] = r_src[i] + qb[i];
      if ({1'b0, s_src[i]} >= trial[i]) begin
        rem_n[i]  = s_src[i] - trial[i][SW-1:0];
        root_n[i] = (r_src[i] >> 1) + qb[i];
      end else begin
        rem_n[i]  = s_src[i];
        root_n[i] = r_src[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        rem[i]  <= rem_n[i];
        root[i] <= root_n[i];
        itm[i]  <= i_src[i];
      end
    end
  end

  assign out_vld  = vld[STEPS-1];
  assign len      = root[STEPS-1][pcrg_pkg::LEN_W-1:0];
  assign out_item = itm[STEPS-1];

endmodule

// ===== design/pcrg_div.sv =====
// Rounded divide of each normalised magnitude by the length, one quotient bit per stage.
module pcrg_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [pcrg_pkg::LEN_W-1:0]        len,
  input  pcrg_pkg::norm_item_t              in_item,
  output logic                              out_vld,
  output logic [2:0][pcrg_pkg::Q_W-1:0]     quo_out,
  output logic [2:0]                        neg_out,
  output logic                              degen_out
);

  localparam int RMW   = pcrg_pkg::REM_W;
  localparam int QW    = pcrg_pkg::Q_W;
  localparam int LW    = pcrg_pkg::LEN_W;
  localparam int STEPS = QW;

  logic [STEPS:0]  vld;
  logic [LW-1:0]   den   [STEPS+1];
  logic [RMW-1:0]  rem   [STEPS+1][3];
  logic [QW-1:0]   quo   [STEPS+1][3];
  logic [2:0]      neg   [STEPS+1];
  logic            degen [STEPS+1];

  logic [RMW-1:0]  trial [STEPS][3];
  logic [RMW-1:0]  rem_n [STEPS][3];
  logic [QW-1:0]   quo_n [STEPS][3];

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      for (int k = 0; k < 3; k++) begin
        trial[i][k] = RMW'(den[i]) << (QW - 1 - i);
        if (rem[i][k] >= trial[i][k]) begin
          rem_n[i][k] = rem[i][k] - trial[i][k];
          quo_n[i][k] = quo[i][k] | (QW'(1) << (QW - 1 - i));
        end else begin
          rem_n[i][k] = rem[i][k];
          quo_n[i][k] = quo[i][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // set-up: numerator carries half the length for rounding
      den[0]   <= len;
      neg[0]   <= in_item.neg;
      degen[0] <= in_item.degen;
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= RMW'({in_item.mag[k], {pcrg_pkg::FRAC_W{1'b0}}}) + RMW'(len >> 1);
        quo[0][k] <= '0;
      end
      for (int i = 0; i < STEPS; i++) begin
        den[i+1]   <= den[i];
        neg[i+1]   <= neg[i];
        degen[i+1] <= degen[i];
        for (int k = 0; k < 3; k++) begin
          rem[i+1][k] <= rem_n[i][k];
          quo[i+1][k] <= quo_n[i][k];
        end
      end
    end
  end

  assign out_vld   = vld[STEPS];
  assign neg_out   = neg[STEPS];
  assign degen_out = degen[STEPS];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo_out[k] = quo[STEPS][k];
    end
  end

endmodule

// ===== design/pinhole_camera_ray_generator_top.sv =====
// Top level of the pinhole camera ray generator.
// Throughput: one request per cycle while the skid register is empty; 8 front stages, 31 root stages, 16 divide stages.
// An output register plus a skid register decouple the pipeline from the output stall.
// Reset (synchronous): clears all valid bits and loads the register reset values.
module pinhole_camera_ray_generator_top #(
  parameter int COORD_WIDTH = pcrg_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pcrg_coord_if.sink  pix,
  pcrg_ray_if.source  ray,
  pcrg_cfg_if.sink    cfg
);

  localparam int DW = pcrg_pkg::DIR_W;
  localparam int LW = pcrg_pkg::LANE_W;
  localparam int QW = pcrg_pkg::Q_W;

  pcrg_pkg::regs_t      regs;
  logic                 en;

  logic                        fr_vld;
  logic [pcrg_pkg::SUM_W-1:0]  fr_sum;
  pcrg_pkg::norm_item_t        fr_item;

  logic                        sq_vld;
  logic [pcrg_pkg::LEN_W-1:0]  sq_len;
  pcrg_pkg::norm_item_t        sq_item;

  logic                        dv_vld;
  logic [2:0][QW-1:0]          dv_quo;
  logic [2:0]                  dv_neg;
  logic                        dv_degen;

  pcrg_pkg::ray_pl_t  res;
  pcrg_pkg::ray_pl_t  out_pl;
  pcrg_pkg::ray_pl_t  skid_pl;
  logic               out_vld;
  logic               skid_vld;
  logic               load_out;
  logic               load_skid;
  logic [QW-1:0]      qc [3];
  logic [DW-1:0]      dmag [3];

  pcrg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign en        = !skid_vld;
  assign pix.ready = en;

  pcrg_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (pix.valid),
    .img_x   (pix.image_x),
    .img_y   (pix.image_y),
    .img_z   (pix.image_z),
    .regs    (regs),
    .out_vld (fr_vld),
    .sum     (fr_sum),
    .item    (fr_item)
  );

  pcrg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fr_vld),
    .sum      (fr_sum),
    .in_item  (fr_item),
    .out_vld  (sq_vld),
    .len      (sq_len),
    .out_item (sq_item)
  );

  pcrg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (sq_vld),
    .len       (sq_len),
    .in_item   (sq_item),
    .out_vld   (dv_vld),
    .quo_out   (dv_quo),
    .neg_out   (dv_neg),
    .degen_out (dv_degen)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k]   = (dv_quo[k] > pcrg_pkg::Q_ONE) ? pcrg_pkg::Q_ONE : dv_quo[k];
      dmag[k] = DW'(qc[k]);
      res.origin[k] = regs.center[LW*k +: LW];
      if (dv_degen) begin
        res.dir[k] = '0;
      end else if (dv_neg[k]) begin
        res.dir[k] = -dmag[k];
      end else begin
        res.dir[k] = dmag[k];
      end
    end
    res.degen = dv_degen;
  end

  assign load_out  = skid_vld ? ray.ready : (dv_vld && (!out_vld || ray.ready));
  assign load_skid = !skid_vld && dv_vld && out_vld && !ray.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld <= 1'b1;
      end else if (ray.ready) begin
        out_vld <= 1'b0;
      end
      if (load_skid) begin
        skid_vld <= 1'b1;
      end else if (ray.ready) begin
        skid_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pl <= skid_vld ? skid_pl : res;
    end
    if (load_skid) begin
      skid_pl <= res;
    end
  end

  assign ray.valid      = out_vld;
  assign ray.origin_x   = out_pl.origin[0];
  assign ray.origin_y   = out_pl.origin[1];
  assign ray.origin_z   = out_pl.origin[2];
  assign ray.dir_x      = out_pl.dir[0];
  assign ray.dir_y      = out_pl.dir[1];
  assign ray.dir_z      = out_pl.dir[2];
  assign ray.degenerate = out_pl.degen;

endmodule
